[design/lpxb_pkg.sv]
package lpxb_pkg;

  localparam int NUM_BINS           = 360;
  localparam int DEFAULT_MAX_POINTS = 8192;
  localparam int RESET_SCAN_COUNT   = 360;

  localparam int SCAN_W       = 14;
  localparam int ANGLE_W      = 16;
  localparam int QUAD_ANGLE_W = 14;
  localparam int DIST_W       = 18;
  localparam int BIN_W        = 9;
  localparam int COORD_W      = 17;

  localparam int FRAC_W          = 16;
  localparam int CORDIC_ITERS    = 16;
  localparam int ITER_W          = 4;
  localparam int CORDIC_W        = 19;
  localparam int CORDIC_GAIN_Q16 = 39797;
  localparam int TWO_PI_Q16      = 411775;
  localparam int TWO_PI_W        = 19;

  localparam int MAG_W       = 18;
  localparam int PROD_W      = MAG_W + DIST_W;
  localparam int SCALE_SHIFT = FRAC_W + 2;
  localparam int COORD_MAX   = 65535;

  // Reciprocal of the bin count for the quotient estimate.
  localparam int RECIP_SHIFT = 20;
  localparam int RECIP_M     = (1 << RECIP_SHIFT) / NUM_BINS;
  localparam int RECIP_W     = 12;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROTATE,
    ST_SCALE_X,
    ST_SCALE_Y,
    ST_EMIT
  } lpxb_state_t;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_EST,
    DIV_FIX
  } lpxb_div_t;

  typedef enum logic [1:0] {
    CRD_IDLE,
    CRD_PREP,
    CRD_RUN
  } lpxb_crd_t;

  typedef enum logic [1:0] {
    QUAD_0,
    QUAD_1,
    QUAD_2,
    QUAD_3
  } lpxb_quad_t;

  typedef struct packed {
    logic             keep;
    logic             last;
    logic [BIN_W-1:0] bin;
  } lpxb_sel_t;

  function automatic logic signed [CORDIC_W-1:0] lpxb_atan(input logic [ITER_W-1:0] i);
    logic signed [CORDIC_W-1:0] r;
    case (i)
      4'd0:    r = CORDIC_W'(51472);
      4'd1:    r = CORDIC_W'(30386);
      4'd2:    r = CORDIC_W'(16055);
      4'd3:    r = CORDIC_W'(8150);
      4'd4:    r = CORDIC_W'(4091);
      4'd5:    r = CORDIC_W'(2047);
      4'd6:    r = CORDIC_W'(1024);
      4'd7:    r = CORDIC_W'(512);
      4'd8:    r = CORDIC_W'(256);
      4'd9:    r = CORDIC_W'(128);
      4'd10:   r = CORDIC_W'(64);
      4'd11:   r = CORDIC_W'(32);
      4'd12:   r = CORDIC_W'(16);
      4'd13:   r = CORDIC_W'(8);
      4'd14:   r = CORDIC_W'(4);
      4'd15:   r = CORDIC_W'(2);
      default: r = '0;
    endcase
    return r;
  endfunction

  // Drops the fraction of |t| * d, saturates and puts the sign back on.
  function automatic logic [COORD_W-1:0] lpxb_sat_coord(input logic [PROD_W-1:0] prod,
                                                        input logic neg);
    logic [PROD_W-SCALE_SHIFT-1:0] whole;
    logic [COORD_W-1:0]            mag;
    whole = prod[PROD_W-1:SCALE_SHIFT];
    if (whole > (PROD_W-SCALE_SHIFT)'(COORD_MAX)) begin
      mag = COORD_W'(COORD_MAX);
    end else begin
      mag = COORD_W'(whole);
    end
    return neg ? -mag : mag;
  endfunction

endpackage

[design/lpxb_cordic.sv]
module lpxb_cordic import lpxb_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [ANGLE_W-1:0]         angle,
  output logic                       done,
  output logic signed [CORDIC_W-1:0] cos_q16,
  output logic signed [CORDIC_W-1:0] sin_q16
);

  localparam int ZS_W       = QUAD_ANGLE_W + TWO_PI_W + 1;
  localparam int ROUND_HALF = 1 << (FRAC_W - 1);

  lpxb_crd_t                  phase, phase_next;
  lpxb_quad_t                 quad;
  logic [QUAD_ANGLE_W-1:0]    frac_angle;
  logic [ITER_W-1:0]          iter;
  logic signed [CORDIC_W-1:0] x, y, z, dx, dy;
  logic [ZS_W-1:0]            z_scaled;
  logic                       last_iter;

  assign last_iter = iter == ITER_W'(CORDIC_ITERS - 1);
  // Angle within the quadrant converted to radians in Q16, rounded.
  assign z_scaled  = ZS_W'(frac_angle) * ZS_W'(TWO_PI_Q16) + ZS_W'(ROUND_HALF);
  assign dx        = y >>> iter;
  assign dy        = x >>> iter;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= CRD_IDLE;
      done  <= 1'b0;
    end else begin
      phase <= phase_next;
      done  <= (phase == CRD_RUN) && last_iter;
    end
  end

  always_comb begin
    phase_next = phase;
    case (phase)
      CRD_IDLE: begin
        if (start) phase_next = CRD_PREP;
      end
      CRD_PREP: phase_next = CRD_RUN;
      CRD_RUN: begin
        if (last_iter) phase_next = CRD_IDLE;
      end
      default: phase_next = CRD_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (start) begin
      frac_angle <= angle[QUAD_ANGLE_W-1:0];
      quad       <= lpxb_quad_t'(angle[ANGLE_W-1 -: 2]);
    end
    if (phase == CRD_PREP) begin
      x    <= CORDIC_W'(CORDIC_GAIN_Q16);
      y    <= '0;
      z    <= CORDIC_W'(z_scaled >> FRAC_W);
      iter <= '0;
    end else if (phase == CRD_RUN) begin
      if (!z[CORDIC_W-1]) begin
        x <= x - dx;
        y <= y + dy;
        z <= z - lpxb_atan(iter);
      end else begin
        x <= x + dx;
        y <= y - dy;
        z <= z + lpxb_atan(iter);
      end
      iter <= iter + ITER_W'(1);
    end
  end

  always_comb begin
    case (quad)
      QUAD_0: begin
        cos_q16 = x;
        sin_q16 = y;
      end
      QUAD_1: begin
        cos_q16 = -y;
        sin_q16 = x;
      end
      QUAD_2: begin
        cos_q16 = -x;
        sin_q16 = -y;
      end
      QUAD_3: begin
        cos_q16 = y;
        sin_q16 = -x;
      end
      default: begin
        cos_q16 = x;
        sin_q16 = y;
      end
    endcase
  end

  a_start_when_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> phase == CRD_IDLE)
    else $error("rotation started while the unit was busy");

  a_done_after_last: assert property (@(posedge clk) disable iff (rst)
    (phase == CRD_RUN) && last_iter |=> done && (phase == CRD_IDLE))
    else $error("rotation did not finish after its last iteration");

  a_done_only_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> phase == CRD_IDLE && !$past(start))
    else $error("done raised while iterating or just started");

endmodule

[design/lpxb_tracker.sv]
module lpxb_tracker import lpxb_pkg::*; #(
  parameter int MAX_POINTS = DEFAULT_MAX_POINTS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [SCAN_W-1:0] cfg_value,
  input  logic              step,
  output logic              busy,
  output lpxb_sel_t         sel
);

  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int QW    = $clog2(MAX_POINTS / NUM_BINS + 1);
  localparam int REM_W = $clog2(NUM_BINS);
  localparam int EST_W = CNT_W + RECIP_W;
  localparam int RST_Q = RESET_SCAN_COUNT / NUM_BINS;
  localparam int RST_R = RESET_SCAN_COUNT % NUM_BINS;

  lpxb_div_t          phase, phase_next;
  logic [CNT_W-1:0]   ordinal, target, target_adv, n_eff, n_clamped;
  logic [BIN_W-1:0]   bin;
  logic [REM_W-1:0]   rem, r_step, fix_rem;
  logic [QW-1:0]      q_step, q_est, fix_q;
  logic [EST_W-1:0]   est_prod;
  logic [CNT_W:0]     diff;
  logic [REM_W:0]     fix_r, rem_sum;
  logic               fix_big, rem_wrap;

  always_comb begin
    if (int'(cfg_value) < NUM_BINS) begin
      n_clamped = CNT_W'(NUM_BINS);
    end else if (int'(cfg_value) > MAX_POINTS) begin
      n_clamped = CNT_W'(MAX_POINTS);
    end else begin
      n_clamped = CNT_W'(cfg_value);
    end
  end

  // The estimate is the true quotient or one below it; one subtraction fixes it.
  assign est_prod = EST_W'(n_eff) * EST_W'(RECIP_M);
  assign diff     = (CNT_W+1)'(n_eff) - (CNT_W+1)'(q_est) * (CNT_W+1)'(NUM_BINS);
  assign fix_r    = diff[REM_W:0];
  assign fix_big  = fix_r >= (REM_W+1)'(NUM_BINS);
  assign fix_q    = fix_big ? q_est + QW'(1) : q_est;
  assign fix_rem  = fix_big ? REM_W'(fix_r - (REM_W+1)'(NUM_BINS)) : REM_W'(fix_r);

  assign rem_sum    = (REM_W+1)'(rem) + (REM_W+1)'(r_step);
  assign rem_wrap   = rem_sum >= (REM_W+1)'(NUM_BINS);
  assign target_adv = target + CNT_W'(q_step) + CNT_W'(rem_wrap);

  assign busy     = phase != DIV_IDLE;
  assign sel.keep = (ordinal + CNT_W'(1)) == target;
  assign sel.last = bin == BIN_W'(NUM_BINS - 1);
  assign sel.bin  = bin;

  always_comb begin
    phase_next = phase;
    case (phase)
      DIV_IDLE: begin
        if (cfg_we) phase_next = DIV_EST;
      end
      DIV_EST: phase_next = DIV_FIX;
      DIV_FIX: phase_next = DIV_IDLE;
      default: phase_next = DIV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= DIV_IDLE;
      ordinal <= '0;
      bin     <= '0;
      target  <= CNT_W'(RST_Q);
      rem     <= REM_W'(RST_R);
      q_step  <= QW'(RST_Q);
      r_step  <= REM_W'(RST_R);
    end else begin
      phase <= phase_next;
      if (phase == DIV_FIX) begin
        q_step  <= fix_q;
        r_step  <= fix_rem;
        target  <= CNT_W'(fix_q);
        rem     <= fix_rem;
        ordinal <= '0;
        bin     <= '0;
      end else if (step) begin
        if (!sel.keep) begin
          ordinal <= ordinal + CNT_W'(1);
        end else if (sel.last) begin
          ordinal <= '0;
          bin     <= '0;
          target  <= CNT_W'(q_step);
          rem     <= r_step;
        end else begin
          ordinal <= ordinal + CNT_W'(1);
          bin     <= bin + BIN_W'(1);
          target  <= target_adv;
          rem     <= rem_wrap ? REM_W'(rem_sum - (REM_W+1)'(NUM_BINS)) : REM_W'(rem_sum);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cfg_we) n_eff <= n_clamped;
    if (phase == DIV_EST) q_est <= QW'(est_prod >> RECIP_SHIFT);
  end

  a_ordinal_below_target: assert property (@(posedge clk) disable iff (rst)
    ordinal < target)
    else $error("point count overtook the next bin target");

  a_rem_in_range: assert property (@(posedge clk) disable iff (rst)
    rem < REM_W'(NUM_BINS))
    else $error("target remainder out of range");

  a_no_step_while_busy: assert property (@(posedge clk) disable iff (rst)
    step |-> !busy)
    else $error("point counted while the step was being recomputed");

endmodule

[design/lidar_polar_to_xy_binner.sv]
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_ready    angle_q14, dist_q2
// out       output     out_valid / out_ready  bin_index, x_mm, y_mm, scan_done
// cfg       input      cfg_valid / cfg_ready  scan_count
//
// A point that fills no bin is taken without leaving ST_IDLE. A kept point passes from its
// transaction to out_valid through the set-up and 16 iterations of the CORDIC stage, then
// through the two passes of the one scaling multiplier and the ST_EMIT state.
// A scan_count write is followed by the DIV_EST and DIV_FIX states, in which the bin step is recomputed.
// The result register lets a new point in while the last result waits; a kept point
// waits in its final state while that register is still full.
// Reset is synchronous and restores a scan of 360 points with no points counted.
module lidar_polar_to_xy_binner import lpxb_pkg::*; #(
  parameter int MAX_POINTS = DEFAULT_MAX_POINTS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [ANGLE_W-1:0]        angle_q14,
  input  logic [DIST_W-1:0]         dist_q2,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [BIN_W-1:0]          bin_index,
  output logic signed [COORD_W-1:0] x_mm,
  output logic signed [COORD_W-1:0] y_mm,
  output logic                      scan_done,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [SCAN_W-1:0]         scan_count
);

  lpxb_state_t                state, state_next;
  lpxb_sel_t                  sel;
  logic                       busy, in_take, cfg_take, crd_start, crd_done;
  logic                       out_free, out_load;
  logic signed [CORDIC_W-1:0] cos_q16, sin_q16, mul_sel;
  logic [MAG_W-1:0]           mul_mag;
  logic [DIST_W-1:0]          point_dist;
  logic [BIN_W-1:0]           bin;
  logic                       last, prod_neg;
  logic [PROD_W-1:0]          prod;
  logic [COORD_W-1:0]         x_res;

  assign in_take   = in_valid && in_ready;
  assign cfg_take  = cfg_valid && cfg_ready;
  assign crd_start = in_take && sel.keep;
  assign out_free  = !out_valid || out_ready;

  lpxb_tracker #(
    .MAX_POINTS(MAX_POINTS)
  ) u_tracker (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_take),
    .cfg_value(scan_count),
    .step     (in_take),
    .busy     (busy),
    .sel      (sel)
  );

  lpxb_cordic u_cordic (
    .clk    (clk),
    .rst    (rst),
    .start  (crd_start),
    .angle  (angle_q14),
    .done   (crd_done),
    .cos_q16(cos_q16),
    .sin_q16(sin_q16)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cfg_ready  = 1'b0;
    out_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready  = !busy;
        cfg_ready = !busy;
        if (crd_start) state_next = ST_ROTATE;
      end
      ST_ROTATE: begin
        if (crd_done) state_next = ST_SCALE_X;
      end
      ST_SCALE_X: state_next = ST_SCALE_Y;
      ST_SCALE_Y: state_next = ST_EMIT;
      ST_EMIT: begin
        out_load = out_free;
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // One multiplier serves both coordinates in turn.
  assign mul_sel = (state == ST_SCALE_X) ? cos_q16 : sin_q16;
  assign mul_mag = MAG_W'(mul_sel[CORDIC_W-1] ? -mul_sel : mul_sel);

  always_ff @(posedge clk) begin
    if (crd_start) begin
      point_dist <= dist_q2;
      bin        <= sel.bin;
      last       <= sel.last;
    end
    if ((state == ST_SCALE_X) || (state == ST_SCALE_Y)) begin
      prod     <= PROD_W'(mul_mag) * PROD_W'(point_dist);
      prod_neg <= mul_sel[CORDIC_W-1];
    end
    if (state == ST_SCALE_Y) begin
      x_res <= lpxb_sat_coord(prod, prod_neg);
    end
    if (out_load) begin
      bin_index <= bin;
      x_mm      <= x_res;
      y_mm      <= lpxb_sat_coord(prod, prod_neg);
      scan_done <= last;
    end
  end

  a_done_in_rotate: assert property (@(posedge clk) disable iff (rst)
    crd_done |-> state == ST_ROTATE)
    else $error("rotation finished outside its wait state");

  a_emit_loads: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) && out_free |=> out_valid && (state == ST_IDLE))
    else $error("finished point was not handed to the result register");

  a_scan_done_last_bin: assert property (@(posedge clk) disable iff (rst)
    out_valid && scan_done |-> bin_index == BIN_W'(NUM_BINS - 1))
    else $error("end of scan flagged on a bin other than the last");

  a_coord_saturated: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (x_mm != {1'b1, {(COORD_W-1){1'b0}}})
               && (y_mm != {1'b1, {(COORD_W-1){1'b0}}}))
    else $error("coordinate beyond the saturation limit");

endmodule
